// ===== sv/trdvk_pkg.sv =====
// ----------------------------------------------------------------------------
// trdvk_pkg
// Shared types and codes for the touch report decoder with virtual keys.
// ----------------------------------------------------------------------------
`default_nettype none

package trdvk_pkg;

   // Fixed field widths
   localparam int unsigned COORD_W = 12;
   localparam int unsigned SLOT_W  = 3;
   localparam int unsigned ID_W    = 4;
   localparam int unsigned KEY_W   = 3;
   localparam int unsigned SPAN_W  = 24;
   localparam int unsigned CSR_IDX_W = 3;

   // Result kinds
   typedef enum logic [2:0] {
      KIND_POINT  = 3'd0,
      KIND_EMPTY  = 3'd1,
      KIND_KEY    = 3'd2,
      KIND_RELALL = 3'd3,
      KIND_SYNC   = 3'd4
   } kind_type;

   // Virtual key codes
   localparam logic [KEY_W-1:0] BTN_NONE   = 3'd0;
   localparam logic [KEY_W-1:0] BTN_MENU   = 3'd1;
   localparam logic [KEY_W-1:0] BTN_HOME   = 3'd2;
   localparam logic [KEY_W-1:0] BTN_BACK   = 3'd3;
   localparam logic [KEY_W-1:0] BTN_SEARCH = 3'd4;

   // Point record event codes (record byte 0, bits 7:6)
   localparam logic [1:0] REC_DOWN = 2'd0;
   localparam logic [1:0] REC_LIFT = 2'd1;
   localparam logic [1:0] REC_HOLD = 2'd2;

   // Report layout
   localparam int unsigned COUNT_POS      = 2;
   localparam int unsigned FIRST_REC_POS  = 3;
   localparam logic [2:0]  REC_OFF_Y_LOW  = 3'd3;
   localparam logic [2:0]  REC_OFF_LAST   = 3'd5;

   // Register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ROW = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MENU    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOME    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BACK    = 3'd4;

   localparam logic [COORD_W-1:0] KEY_ROW_RST     = 12'd821;
   localparam logic [SPAN_W-1:0]  MENU_SPAN_RST   = 24'd409620;
   localparam logic [SPAN_W-1:0]  HOME_SPAN_RST   = 24'd868504;
   localparam logic [SPAN_W-1:0]  SEARCH_SPAN_RST = 24'd1360144;
   localparam logic [SPAN_W-1:0]  BACK_SPAN_RST   = 24'd1876346;

   // Command queue depth between front and back
   localparam int unsigned CMDQ_DEPTH = 2;

   // Work handed from front to back for one byte
   typedef struct packed {
      logic               decode;
      logic               sync;
      logic [SLOT_W-1:0]  slot;
      logic [1:0]         rec_event;
      logic [ID_W-1:0]    track_id;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic               count_zero;
   } cmd_type;

   // One result beat (last_of_run is added at the output)
   typedef struct packed {
      kind_type           kind;
      logic [SLOT_W-1:0]  slot;
      logic [ID_W-1:0]    track_id;
      logic               pressed;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [KEY_W-1:0]   key_code;
      logic               key_press;
   } event_type;

endpackage

`default_nettype wire

// ===== sv/touch_report_decoder_virtual_keys_top.sv =====
// ----------------------------------------------------------------------------
// touch_report_decoder_virtual_keys_top
// Touch report decoder with virtual keys: byte stream in, point, key and
// frame sync events out.
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+---------------------------------
//  req_     | in        | push / full      | report_byte, start_of_report
//  rsp_     | out       | empty / pop      | event fields, last_of_run
//  csr_     | in        | we (no wait)     | index, wdata (24 bits)
//
// A byte is taken in the cycle it is pushed while the command queue has room.
// The back builds all 1 to 4 beats of a command when it loads it and hands out one
// beat per cycle while rsp_pop is held; the next command loads in the cycle
// the last beat is popped. Synchronous reset, no clearing pass.
// A stalled result side fills the two-entry command queue, then raises full.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_report_decoder_virtual_keys_top #(
   parameter int unsigned MAX_POINTS   = 2,
   parameter int unsigned REPORT_BYTES = 15
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // report bytes
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_report_byte,
   input  wire logic        req_start_of_report,
   // events
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [2:0]       rsp_event_kind,
   output logic [2:0]       rsp_point_slot,
   output logic [3:0]       rsp_track_id,
   output logic             rsp_pressed,
   output logic [11:0]      rsp_pos_x,
   output logic [11:0]      rsp_pos_y,
   output logic [2:0]       rsp_key_code,
   output logic             rsp_key_press,
   output logic             rsp_last_of_run,
   // configuration
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_wdata
);
   import trdvk_pkg::*;

   cmd_type   push_cmd, head_cmd;
   event_type head_event;
   logic      accept, cmd_push, cmd_valid, cmd_pop;

   assign accept = req_push && !req_full;

   trdvk_front #(
      .MAX_POINTS   (MAX_POINTS),
      .REPORT_BYTES (REPORT_BYTES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .report_byte     (req_report_byte),
      .start_of_report (req_start_of_report),
      .cmd_push        (cmd_push),
      .cmd             (push_cmd)
   );

   trdvk_cmd_queue u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (push_cmd),
      .full     (req_full),
      .pop      (cmd_pop),
      .valid    (cmd_valid),
      .head     (head_cmd)
   );

   trdvk_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_valid (cmd_valid),
      .cmd       (head_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_event (head_event),
      .rsp_last  (rsp_last_of_run)
   );

   // Break the head beat out onto the result ports
   assign rsp_event_kind = head_event.kind;
   assign rsp_point_slot = head_event.slot;
   assign rsp_track_id   = head_event.track_id;
   assign rsp_pressed    = head_event.pressed;
   assign rsp_pos_x      = head_event.pos_x;
   assign rsp_pos_y      = head_event.pos_y;
   assign rsp_key_code   = head_event.key_code;
   assign rsp_key_press  = head_event.key_press;

endmodule

`default_nettype wire

// ===== sv/trdvk_front.sv =====
// ----------------------------------------------------------------------------
// trdvk_front
// Tracks the byte position in a report, collects point records and hands
// one command per byte that needs slot decoding or a frame sync.
// ----------------------------------------------------------------------------
`default_nettype none

module trdvk_front #(
   parameter int unsigned MAX_POINTS   = 2,
   parameter int unsigned REPORT_BYTES = 15
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        report_byte,
   input  wire logic              start_of_report,
   output logic                   cmd_push,
   output trdvk_pkg::cmd_type     cmd
);
   import trdvk_pkg::*;

   localparam int unsigned POS_W = $clog2(REPORT_BYTES + 1);
   localparam int unsigned PC_W  = $clog2(MAX_POINTS + 1);

   logic [POS_W-1:0]  byte_position_ff, byte_position_in;
   logic [PC_W-1:0]   point_count_ff, point_count_in;
   logic [PC_W-1:0]   prev_count_ff, prev_count_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [2:0]        offset_ff, offset_in;
   logic [23:0]       partial_ff, partial_in;

   logic [POS_W-1:0]  pos;
   logic              in_report;
   logic              record_byte;
   logic              decode;
   logic              sync;
   logic [PC_W-1:0]   clamped;

   // Position and classification of the incoming byte
   always_comb begin
      pos         = start_of_report ? '0 : byte_position_ff;
      in_report   = pos < POS_W'(REPORT_BYTES);
      record_byte = in_report && (pos >= POS_W'(FIRST_REC_POS))
                    && (slot_ff < SLOT_W'(MAX_POINTS));
      decode      = record_byte && (offset_ff == REC_OFF_Y_LOW)
                    && (slot_ff < SLOT_W'(prev_count_ff));
      sync        = pos == POS_W'(REPORT_BYTES - 1);
      if (report_byte[3:0] > 4'(MAX_POINTS)) begin
         clamped = PC_W'(MAX_POINTS);
      end else begin
         clamped = PC_W'(report_byte[3:0]);
      end
   end

   // Next state
   always_comb begin
      byte_position_in = byte_position_ff;
      point_count_in   = point_count_ff;
      prev_count_in    = prev_count_ff;
      slot_in          = slot_ff;
      offset_in        = offset_ff;
      partial_in       = partial_ff;
      if (accept) begin
         if (!in_report) begin
            byte_position_in = pos;
         end else begin
            if (pos == POS_W'(COUNT_POS)) begin
               point_count_in = clamped;
               if (prev_count_ff < clamped) begin
                  prev_count_in = clamped;
               end
            end
            // slot/offset counters stand in for (pos-3)/6 and (pos-3)%6
            if (pos < POS_W'(FIRST_REC_POS)) begin
               slot_in   = '0;
               offset_in = '0;
            end else if (offset_ff == REC_OFF_LAST) begin
               slot_in   = slot_ff + 1'b1;
               offset_in = '0;
            end else begin
               offset_in = offset_ff + 1'b1;
            end
            if (record_byte && (offset_ff < REC_OFF_Y_LOW)) begin
               partial_in = {partial_ff[15:0], report_byte};
            end
            if (sync) begin
               prev_count_in    = point_count_ff;
               byte_position_in = POS_W'(REPORT_BYTES);
            end else begin
               byte_position_in = pos + 1'b1;
            end
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= '0;
         point_count_ff   <= '0;
         prev_count_ff    <= '0;
         slot_ff          <= '0;
         offset_ff        <= '0;
      end else begin
         byte_position_ff <= byte_position_in;
         point_count_ff   <= point_count_in;
         prev_count_ff    <= prev_count_in;
         slot_ff          <= slot_in;
         offset_ff        <= offset_in;
      end
      partial_ff <= partial_in;
   end

   // Command toward the back
   always_comb begin
      cmd_push       = accept && in_report && (decode || sync);
      cmd.decode     = decode;
      cmd.sync       = sync;
      cmd.slot       = slot_ff;
      cmd.rec_event  = partial_ff[23:22];
      cmd.track_id   = partial_ff[7:4];
      cmd.pos_x      = {partial_ff[19:16], partial_ff[15:8]};
      cmd.pos_y      = {partial_ff[3:0], report_byte};
      cmd.count_zero = point_count_ff == '0;
   end

endmodule

`default_nettype wire

// ===== sv/trdvk_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// trdvk_cmd_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module trdvk_cmd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire trdvk_pkg::cmd_type push_cmd,
   output logic                    full,
   input  wire logic               pop,
   output logic                    valid,
   output trdvk_pkg::cmd_type      head
);
   import trdvk_pkg::*;

   localparam int unsigned PTR_W = $clog2(CMDQ_DEPTH);
   localparam int unsigned CNT_W = $clog2(CMDQ_DEPTH + 1);

   cmd_type            entry_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   // Pointer and fill tracking
   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign full  = count_ff == CNT_W'(CMDQ_DEPTH);
   assign valid = count_ff != '0;
   assign head  = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== sv/trdvk_back.sv =====
// ----------------------------------------------------------------------------
// trdvk_back
// Runs slot decoding and virtual key tracking for one command, buffers the
// up to four result beats it causes and hands them out one per pop.
// ----------------------------------------------------------------------------
`default_nettype none

module trdvk_back #(
   parameter int unsigned MAX_POINTS = 2
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [trdvk_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [trdvk_pkg::SPAN_W-1:0]      csr_wdata,
   input  wire logic                              cmd_valid,
   input  wire trdvk_pkg::cmd_type                cmd,
   output logic                                   cmd_pop,
   input  wire logic                              rsp_pop,
   output logic                                   rsp_empty,
   output trdvk_pkg::event_type                   rsp_event,
   output logic                                   rsp_last
);
   import trdvk_pkg::*;

   // Configuration
   logic [COORD_W-1:0] key_row_ff;
   logic [SPAN_W-1:0]  menu_span_ff, home_span_ff, search_span_ff, back_span_ff;

   // Key and slot state
   logic [KEY_W-1:0]      held_key_ff, held_key_in;
   logic                  key_active_ff, key_active_in;
   logic [MAX_POINTS-1:0] slot_pressed_ff, slot_pressed_in;

   // Result buffer
   event_type  ev_buf_ff [4];
   event_type  ev_list   [4];
   logic [1:0] idx_ff, last_idx_ff;
   logic       busy_ff;
   logic [2:0] n;

   logic             pop_fire, done, load;
   logic             in_row;
   logic [KEY_W-1:0] key;
   logic             pressed;
   event_type        ev;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         key_row_ff     <= KEY_ROW_RST;
         menu_span_ff   <= MENU_SPAN_RST;
         home_span_ff   <= HOME_SPAN_RST;
         search_span_ff <= SEARCH_SPAN_RST;
         back_span_ff   <= BACK_SPAN_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY_ROW: key_row_ff     <= csr_wdata[COORD_W-1:0];
            CSR_MENU:    menu_span_ff   <= csr_wdata;
            CSR_HOME:    home_span_ff   <= csr_wdata;
            CSR_SEARCH:  search_span_ff <= csr_wdata;
            CSR_BACK:    back_span_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Key window lookup, menu, home, back, search in that order
   always_comb begin
      in_row = cmd.pos_y > key_row_ff;
      if (cmd.pos_x > menu_span_ff[11:0] && cmd.pos_x < menu_span_ff[23:12]) begin
         key = BTN_MENU;
      end else if (cmd.pos_x > home_span_ff[11:0] && cmd.pos_x < home_span_ff[23:12]) begin
         key = BTN_HOME;
      end else if (cmd.pos_x > back_span_ff[11:0] && cmd.pos_x < back_span_ff[23:12]) begin
         key = BTN_BACK;
      end else if (cmd.pos_x > search_span_ff[11:0]
                   && cmd.pos_x < search_span_ff[23:12]) begin
         key = BTN_SEARCH;
      end else begin
         key = BTN_NONE;
      end
   end

   // Build the result list and next key state for the head command
   always_comb begin
      held_key_in     = held_key_ff;
      key_active_in   = key_active_ff;
      slot_pressed_in = slot_pressed_ff;
      pressed         = 1'b0;
      n               = '0;
      for (int i = 0; i < 4; i++) begin
         ev_list[i] = '0;
      end
      ev      = '0;
      ev.slot = cmd.slot;

      if (cmd.decode) begin
         if (in_row) begin
            if (cmd.rec_event == REC_DOWN) begin
               held_key_in = key;
               if (key != BTN_NONE) begin
                  ev.kind = KIND_KEY; ev.key_code = key; ev.key_press = 1'b1;
                  ev_list[n[1:0]] = ev; n = n + 1'b1;
                  ev = '0; ev.slot = cmd.slot;
               end
               key_active_in = 1'b1;
            end else if (cmd.rec_event == REC_LIFT) begin
               if (held_key_in != key && held_key_in != BTN_NONE) begin
                  ev.kind = KIND_RELALL;
                  ev_list[n[1:0]] = ev; n = n + 1'b1;
                  ev = '0; ev.slot = cmd.slot;
                  held_key_in = BTN_NONE;
               end
               if (key != BTN_NONE) begin
                  ev.kind = KIND_KEY; ev.key_code = key; ev.key_press = 1'b0;
                  ev_list[n[1:0]] = ev; n = n + 1'b1;
                  ev = '0; ev.slot = cmd.slot;
               end
               key_active_in = 1'b0;
            end
         end
         // Per-slot pressed state; a lift also ends a key touch
         for (int s = 0; s < MAX_POINTS; s++) begin
            if (cmd.slot == SLOT_W'(s)) begin
               if (cmd.rec_event == REC_DOWN || cmd.rec_event == REC_HOLD) begin
                  slot_pressed_in[s] = 1'b1;
               end else if (cmd.rec_event == REC_LIFT) begin
                  slot_pressed_in[s] = 1'b0;
               end
               pressed = slot_pressed_in[s];
            end
         end
         if (cmd.rec_event == REC_LIFT && key_active_in) begin
            if (held_key_in != BTN_NONE) begin
               ev.kind = KIND_RELALL;
               ev_list[n[1:0]] = ev; n = n + 1'b1;
               ev = '0; ev.slot = cmd.slot;
               held_key_in = BTN_NONE;
            end
            key_active_in = 1'b0;
         end
         // Point or empty point for the slot
         if (cmd.count_zero) begin
            ev.kind = KIND_EMPTY;
         end else begin
            ev.kind     = KIND_POINT;
            ev.track_id = cmd.track_id;
            ev.pressed  = pressed;
            ev.pos_x    = cmd.pos_x;
            ev.pos_y    = cmd.pos_y;
         end
         ev_list[n[1:0]] = ev; n = n + 1'b1;
      end
      // Frame sync last
      if (cmd.sync) begin
         ev      = '0;
         ev.kind = KIND_SYNC;
         ev_list[n[1:0]] = ev; n = n + 1'b1;
      end
   end

   // Load and drain control
   always_comb begin
      pop_fire = rsp_pop && busy_ff;
      done     = pop_fire && (idx_ff == last_idx_ff);
      load     = cmd_valid && (!busy_ff || done);
      cmd_pop  = load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b0;
         idx_ff          <= '0;
         last_idx_ff     <= '0;
         held_key_ff     <= BTN_NONE;
         key_active_ff   <= 1'b0;
         slot_pressed_ff <= '0;
      end else if (load) begin
         busy_ff         <= 1'b1;
         idx_ff          <= '0;
         last_idx_ff     <= 2'(n - 1'b1);
         held_key_ff     <= held_key_in;
         key_active_ff   <= key_active_in;
         slot_pressed_ff <= slot_pressed_in;
      end else if (done) begin
         busy_ff <= 1'b0;
      end else if (pop_fire) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (load) begin
         for (int i = 0; i < 4; i++) begin
            ev_buf_ff[i] <= ev_list[i];
         end
      end
   end

   // Output head
   assign rsp_empty = !busy_ff;
   assign rsp_event = ev_buf_ff[idx_ff];
   assign rsp_last  = idx_ff == last_idx_ff;

`ifndef NO_ASSERTIONS
   // Draining never runs past the last buffered beat
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> idx_ff <= last_idx_ff)
      else $error("result index past last beat");

   // A loaded command always shows a beat on the next cycle
   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      load |=> busy_ff)
      else $error("loaded command produced no beat");

   // A held key is always one of the defined key codes
   a_held_key: assert property (@(posedge clock) disable iff (reset)
      held_key_ff <= BTN_SEARCH)
      else $error("held key out of range");

   // Frame sync is only ever the last beat of a run
   a_sync_last: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && rsp_event.kind == KIND_SYNC) |-> rsp_last)
      else $error("frame sync not last");
`endif

endmodule

`default_nettype wire
